/* rtl/core/sle_pkg.sv */
// Package for the sorted list engine: sizes, operation and status codes,
// and the control bundle broadcast along the cell chain. No dependencies.
package sle_pkg;

   localparam int CAPACITY      = 16;
   localparam int KEY_W         = 32;
   localparam int COUNT_W       = $clog2(CAPACITY + 1);
   localparam int ENTRY_COUNT_W = 5;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_SEARCH = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic do_insert;
      logic do_delete;
   } cell_ctrl_type;

   typedef struct packed {
      logic le;   // holds an entry <= key
      logic lt;   // holds an entry < key
      logic eq;   // holds an entry == key
   } cell_flags_type;

endpackage

/* rtl/core/sorted_list_engine.sv */
// Sorted list engine top level: a chain of sle_cell entries kept ascending.
// Each accepted request's response is registered at the edge that accepts it.
// Throughput: one request per cycle while no response waits under rsp_stall; every cell
// compares the broadcast key in parallel and shifts toward its neighbor in the same cycle.
// Reset (synchronous, active high) empties the list and drops any response.
// Depends on sle_pkg and sle_cell.
module sorted_list_engine
   import sle_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_kind,
   input  logic signed [KEY_W-1:0]  req_key_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [ENTRY_COUNT_W-1:0] rsp_entry_count
);

   // Cell chain wiring
   logic signed [KEY_W-1:0] cell_value [CAPACITY];
   logic                    cell_valid [CAPACITY];
   cell_flags_type          cell_flags [CAPACITY];
   logic [CAPACITY-1:0]     eq_vec;
   cell_ctrl_type           ctrl;

   // Fill count and response register
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, status_in;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count_ff;

   logic accept;
   logic any_match;
   logic list_empty;
   logic list_full;

   // Hold the request while a finished response waits to be taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == COUNT_W'(CAPACITY));
   assign any_match  = |eq_vec;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic signed [KEY_W-1:0] left_value, right_value;
         logic                    left_valid, left_le, right_valid;

         // The head of the chain sees an always-smaller left neighbor;
         // the tail sees an empty right neighbor.
         if (g == 0) begin : g_head
            assign left_value = req_key_value;
            assign left_valid = 1'b1;
            assign left_le    = 1'b1;
         end else begin : g_body
            assign left_value = cell_value[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_le    = cell_flags[g-1].le;
         end

         if (g == CAPACITY - 1) begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
         end else begin : g_inner
            assign right_value = cell_value[g+1];
            assign right_valid = cell_valid[g+1];
         end

         sle_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .key         (req_key_value),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .left_le     (left_le),
            .right_value (right_value),
            .right_valid (right_valid),
            .value       (cell_value[g]),
            .valid       (cell_valid[g]),
            .flags       (cell_flags[g])
         );

         assign eq_vec[g] = cell_flags[g].eq;
      end
   endgenerate

   // Decode the request: pick the chain action, status and next count.
   always_comb begin
      ctrl.do_insert = 1'b0;
      ctrl.do_delete = 1'b0;
      count_in       = count_ff;
      status_in      = STATUS_DONE;
      case (req_kind)
         KIND_INSERT: begin
            if (list_full) begin
               // drop the value and flag it
               status_in = STATUS_FULL;
            end else begin
               ctrl.do_insert = accept;
               if (accept) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
         end
         KIND_DELETE: begin
            if (list_empty) begin
               status_in = STATUS_EMPTY;
            end else if (!any_match) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               ctrl.do_delete = accept;
               if (accept) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
         end
         default: begin
            // search, and the unused code treated as a search
            if (list_empty) begin
               status_in = STATUS_EMPTY;
            end else if (!any_match) begin
               status_in = STATUS_NOT_FOUND;
            end
         end
      endcase
   end

   // Advance the response register when it is empty or being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff      <= status_in;
         rsp_entry_count_ff <= ENTRY_COUNT_W'(count_in);
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

/* rtl/core/sle_cell.sv */
// One storage cell of the sorted list chain: one entry plus its valid bit.
// Depends on sle_pkg.
module sle_cell
   import sle_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctrl_type           ctrl,
   input  logic signed [KEY_W-1:0] key,
   input  logic signed [KEY_W-1:0] left_value,
   input  logic                    left_valid,
   input  logic                    left_le,
   input  logic signed [KEY_W-1:0] right_value,
   input  logic                    right_valid,
   output logic signed [KEY_W-1:0] value,
   output logic                    valid,
   output cell_flags_type          flags
);

   logic signed [KEY_W-1:0] value_ff, value_in;
   logic                    valid_ff, valid_in;

   always_comb begin
      flags.le = valid_ff && (value_ff <= key);
      flags.lt = valid_ff && (value_ff < key);
      flags.eq = valid_ff && (value_ff == key);
   end

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.do_insert && !flags.le) begin
         // open a slot: the first cell past the insert point takes the key
         if (left_le) begin
            value_in = key;
            valid_in = 1'b1;
         end else begin
            value_in = left_value;
            valid_in = left_valid;
         end
      end else if (ctrl.do_delete && valid_ff && !flags.lt) begin
         // close the gap from the first match onward
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule
